// File: rtl/mmad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmad_pkg: shared types and constants of the memory map access decoder
// Target codes, size codes, address windows and the transaction structs.
// ----------------------------------------------------------------------------
package mmad_pkg;

  localparam int AddrW   = 32;
  localparam int DataW   = 32;
  localparam int OffW    = 26;
  localparam int RomMskW = 25;
  localparam int LatchW  = 14;
  localparam int PaddrW  = 4;

  // target codes
  localparam logic [3:0] TGT_BOOT    = 4'd0;
  localparam logic [3:0] TGT_EWRAM   = 4'd1;
  localparam logic [3:0] TGT_IWRAM   = 4'd2;
  localparam logic [3:0] TGT_IO      = 4'd3;
  localparam logic [3:0] TGT_PAL     = 4'd4;
  localparam logic [3:0] TGT_VRAM    = 4'd5;
  localparam logic [3:0] TGT_OAM     = 4'd6;
  localparam logic [3:0] TGT_ROM     = 4'd7;
  localparam logic [3:0] TGT_EEPROM  = 4'd8;
  localparam logic [3:0] TGT_GPIO    = 4'd9;
  localparam logic [3:0] TGT_BACKUP  = 4'd10;
  localparam logic [3:0] TGT_OPEN    = 4'd11;
  localparam logic [3:0] TGT_ZERO    = 4'd12;
  localparam logic [3:0] TGT_DROP    = 4'd13;
  localparam logic [3:0] TGT_PATTERN = 4'd14;

  // access size codes
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;
  localparam logic [1:0] SZ_RSVD = 2'd3;

  // register indexes
  localparam logic [1:0] REG_ROM_MASK   = 2'd0;
  localparam logic [1:0] REG_ROM_OVER   = 2'd1;
  localparam logic [1:0] REG_EEPROM     = 2'd2;
  localparam logic [1:0] REG_CLOCK      = 2'd3;

  localparam logic [RomMskW-1:0] ROM_MASK_RESET = 25'h1ffffff;

  // address windows
  localparam logic [AddrW-1:0] BOOT_END     = 32'h0000_4000;
  localparam logic [AddrW-1:0] EE_LO_SMALL  = 32'h0d00_0000;
  localparam logic [AddrW-1:0] EE_LO_LARGE  = 32'h0dff_ff00;
  localparam logic [AddrW-1:0] GPIO_LO      = 32'h0800_00c4;
  localparam logic [AddrW-1:0] GPIO_HI      = 32'h0800_00ca;
  localparam logic [16:0]      VRAM_MIRROR  = 17'h18000;
  localparam logic [16:0]      VRAM_BYTE_BM = 17'h14000;
  localparam logic [16:0]      VRAM_BYTE    = 17'h10000;

  typedef struct packed {
    logic             cmd;
    logic [1:0]       access_size;
    logic [AddrW-1:0] bus_address;
    logic [DataW-1:0] write_data;
    logic             pc_in_boot_rom;
    logic             bitmap_mode;
  } mmad_item_t;

  typedef struct packed {
    logic [3:0]       target;
    logic [OffW-1:0]  offset;
    logic [1:0]       effective_size;
    logic [DataW-1:0] bus_data;
    logic [1:0]       lane_shift;
  } mmad_result_t;

  typedef struct packed {
    logic [RomMskW-1:0] rom_mask;
    logic               rom_over_16m;
    logic               eeprom_present;
    logic               clock_present;
  } mmad_cfg_t;

  typedef struct packed {
    logic              we;
    logic [LatchW-1:0] value;
  } mmad_latch_upd_t;

endpackage

// File: rtl/memory_map_access_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_map_access_decoder_top: bus access decoder
// Pipeline: an accepted transaction loads the input register, then moves into
//   the result register; throughput one transaction per cycle while the result
//   channel is not stalled.
// The decode logic sits combinationally between the two registers.
// Reset (synchronous): clears both valid flags, the boot ROM latch and loads
//   the configuration reset values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module memory_map_access_decoder_top
  import mmad_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cmd,
  input  logic [1:0]        access_size,
  input  logic [AddrW-1:0]  bus_address,
  input  logic [DataW-1:0]  write_data,
  input  logic              pc_in_boot_rom,
  input  logic              bitmap_mode,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        target,
  output logic [OffW-1:0]   offset,
  output logic [1:0]        effective_size,
  output logic [DataW-1:0]  bus_data,
  output logic [1:0]        lane_shift,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  mmad_cfg_t         cfg;
  mmad_item_t        item;       // input register
  logic              item_valid;
  mmad_result_t      res_next;
  mmad_result_t      res;        // result register
  mmad_latch_upd_t   latch_upd;
  logic [LatchW-1:0] boot_latch;
  logic              advance;    // input register moves into result register
  logic              load_in;

  mmad_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The result register frees up whenever it is empty or being taken;
  // the input register frees up whenever its transaction advances.
  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;
  assign load_in  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load_in) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  // hold the payload while stalled
  always_ff @(posedge clk) begin
    if (load_in) begin
      item.cmd            <= cmd;
      item.access_size    <= access_size;
      item.bus_address    <= bus_address;
      item.write_data     <= write_data;
      item.pc_in_boot_rom <= pc_in_boot_rom;
      item.bitmap_mode    <= bitmap_mode;
    end
  end

  mmad_decode u_decode (
    .item       (item),
    .cfg        (cfg),
    .boot_latch (boot_latch),
    .res        (res_next),
    .latch_upd  (latch_upd)
  );

  // The boot ROM latch changes only when its transaction leaves the input
  // register, so transactions see it strictly in order.
  always_ff @(posedge clk) begin
    if (rst) begin
      boot_latch <= '0;
    end else if (advance && latch_upd.we) begin
      boot_latch <= latch_upd.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign target         = res.target;
  assign offset         = res.offset;
  assign effective_size = res.effective_size;
  assign bus_data       = res.bus_data;
  assign lane_shift     = res.lane_shift;

endmodule

// File: rtl/mmad_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmad_cfg_regs: configuration register file
// APB-style write and read access to the cartridge configuration.
// ----------------------------------------------------------------------------
module mmad_cfg_regs
  import mmad_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output mmad_cfg_t         cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rom_mask       <= ROM_MASK_RESET;
      cfg.rom_over_16m   <= 1'b0;
      cfg.eeprom_present <= 1'b0;
      cfg.clock_present  <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ROM_MASK: cfg.rom_mask       <= pwdata[RomMskW-1:0];
        REG_ROM_OVER: cfg.rom_over_16m   <= pwdata[0];
        REG_EEPROM:   cfg.eeprom_present <= pwdata[0];
        REG_CLOCK:    cfg.clock_present  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ROM_MASK: prdata = {{(32-RomMskW){1'b0}}, cfg.rom_mask};
      REG_ROM_OVER: prdata = {31'd0, cfg.rom_over_16m};
      REG_EEPROM:   prdata = {31'd0, cfg.eeprom_present};
      REG_CLOCK:    prdata = {31'd0, cfg.clock_present};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

// File: rtl/mmad_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmad_decode: single-pass address decode
// Region select, offset masking and mirroring, byte widening, ROM pattern.
// ----------------------------------------------------------------------------
module mmad_decode
  import mmad_pkg::*;
(
  input  mmad_item_t        item,
  input  mmad_cfg_t         cfg,
  input  logic [LatchW-1:0] boot_latch,
  output mmad_result_t      res,
  output mmad_latch_upd_t   latch_upd
);

  logic             wr;
  logic [1:0]       sz;
  logic [AddrW-1:0] a;
  logic [AddrW-1:0] align;
  logic [AddrW-1:0] a_al;
  logic [7:0]       region;
  logic             byte_wr;
  logic             widen;
  logic [16:0]      v;
  logic [RomMskW-1:0] base;
  logic [15:0]      h;
  logic [DataW-1:0] pattern;
  logic [AddrW-1:0] ee_lo;
  logic [DataW-1:0] wdata_msk;

  always_comb begin
    wr      = item.cmd;
    sz      = (item.access_size == SZ_RSVD) ? SZ_WORD : item.access_size;
    a       = item.bus_address;
    case (sz)
      SZ_BYTE: align = 32'hffff_ffff;
      SZ_HALF: align = 32'hffff_fffe;
      default: align = 32'hffff_fffc;
    endcase
    a_al    = a & align;
    region  = a[31:24];
    byte_wr = wr && (sz == SZ_BYTE);

    case (sz)
      SZ_BYTE: wdata_msk = {24'd0, item.write_data[7:0]};
      SZ_HALF: wdata_msk = {16'd0, item.write_data[15:0]};
      default: wdata_msk = item.write_data;
    endcase

    // video offset, byte writes land on the even address
    v = {a_al[16:1], a_al[0] & ~byte_wr};

    // ROM pattern from the aligned offset
    base = a_al[RomMskW-1:0];
    h    = base[16:1];
    case (sz)
      SZ_BYTE: pattern = {24'd0, base[0] ? h[15:8] : h[7:0]};
      SZ_HALF: pattern = {16'd0, h};
      default: pattern = {h[15:1], 1'b1, h[15:1], 1'b0};
    endcase
    ee_lo = cfg.rom_over_16m ? EE_LO_LARGE : EE_LO_SMALL;

    res.target         = TGT_DROP;
    res.offset         = '0;
    res.effective_size = sz;
    res.bus_data       = wr ? wdata_msk : '0;
    res.lane_shift     = 2'd0;
    widen              = 1'b0;
    latch_upd.we       = 1'b0;
    latch_upd.value    = a_al[LatchW-1:0];

    case (region)
      8'h00: begin
        if (a >= BOOT_END) begin
          res.target = wr ? TGT_DROP : TGT_OPEN;
        end else if (!wr) begin
          latch_upd.we = item.pc_in_boot_rom;
          res.target   = TGT_BOOT;
          // the latch follows this read when the program runs from boot ROM
          res.offset   = {{(OffW-LatchW){1'b0}},
                          item.pc_in_boot_rom ? a_al[LatchW-1:0] : boot_latch};
        end
      end
      8'h02: begin
        res.target = TGT_EWRAM;
        res.offset = {8'd0, a_al[17:0]};
      end
      8'h03: begin
        res.target = TGT_IWRAM;
        res.offset = {11'd0, a_al[14:0]};
      end
      8'h04: begin
        res.target = TGT_IO;
        res.offset = a_al[OffW-1:0];
      end
      8'h05: begin
        res.target = TGT_PAL;
        res.offset = {16'd0, a_al[9:1], a_al[0] & ~byte_wr};
        widen      = byte_wr;
      end
      8'h06: begin
        if (item.bitmap_mode && (v >= VRAM_MIRROR)) begin
          res.target = wr ? TGT_DROP : TGT_ZERO;
        end else if (byte_wr) begin
          if (v >= (item.bitmap_mode ? VRAM_BYTE_BM : VRAM_BYTE)) begin
            res.target = TGT_DROP;
          end else begin
            res.target = TGT_VRAM;
            res.offset = {9'd0, v};
            widen      = 1'b1;
          end
        end else begin
          // upper 32 KiB mirrors the object area: drop bit 15
          res.target = TGT_VRAM;
          res.offset = {9'd0, v[16], v[15] & ~v[16], v[14:0]};
        end
      end
      8'h07: begin
        if (!byte_wr) begin
          res.target = TGT_OAM;
          res.offset = {16'd0, a_al[9:0]};
        end
      end
      8'h08, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d: begin
        if ((sz == SZ_HALF) && cfg.eeprom_present && (a >= ee_lo)) begin
          res.target = TGT_EEPROM;
        end else if ((sz == SZ_HALF) && cfg.clock_present &&
                     (a >= GPIO_LO) && (a < GPIO_HI)) begin
          res.target = TGT_GPIO;
          res.offset = {1'b0, a[24:1], 1'b0};
        end else if (wr) begin
          res.target = TGT_DROP;
        end else if (base > cfg.rom_mask) begin
          res.target   = TGT_PATTERN;
          res.offset   = {1'b0, base};
          res.bus_data = pattern;
        end else begin
          res.target = TGT_ROM;
          res.offset = {1'b0, base & cfg.rom_mask};
        end
      end
      8'h0e, 8'h0f: begin
        res.target = TGT_BACKUP;
        res.offset = {10'd0, a[15:0]};
      end
      default: begin
        res.target = wr ? TGT_DROP : TGT_OPEN;
      end
    endcase

    if (res.target == TGT_OPEN) begin
      case (sz)
        SZ_BYTE: res.lane_shift = a[1:0];
        SZ_HALF: res.lane_shift = {a[1], 1'b0};
        default: res.lane_shift = 2'd0;
      endcase
    end
    if (widen) begin
      res.effective_size = SZ_HALF;
      res.bus_data       = {16'd0, item.write_data[7:0], item.write_data[7:0]};
    end
  end

endmodule

// File: rtl/mmad_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmad_checker: port-level checks of the access decoder
// Watches the result channel and the meaning of the result fields.
// ----------------------------------------------------------------------------
module mmad_checker
  import mmad_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_stall,
  input logic [3:0]       target,
  input logic [OffW-1:0]  offset,
  input logic [1:0]       effective_size,
  input logic [1:0]       lane_shift
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(target) && $stable(offset))
    else $error("result changed while stalled");

  // only open-bus reads carry a byte lane
  a_lane_open: assert property (@(posedge clk) disable iff (rst)
    out_valid && (lane_shift != 2'd0) |-> (target == TGT_OPEN))
    else $error("lane shift on a non open-bus target");

  // targets without a location report offset zero
  a_off_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((target == TGT_DROP) || (target == TGT_OPEN) ||
                  (target == TGT_EEPROM) || (target == TGT_ZERO)) |-> (offset == '0))
    else $error("nonzero offset on a target without storage");

  // the effective size never reports the reserved code
  a_size_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (effective_size != SZ_RSVD))
    else $error("reserved effective size");

endmodule

bind memory_map_access_decoder_top mmad_checker u_mmad_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .target         (target),
  .offset         (offset),
  .effective_size (effective_size),
  .lane_shift     (lane_shift)
);
